/* design/tbt_pkg.sv */
// Package for the per-triangle tangent/bitangent block.
// Holds the sequencer state type, pass codes and vertex phase codes.
// No dependencies.
package tbt_pkg;

    // Sequencer states of the shared multiplier / divider datapath
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_SUB,
        ST_NORM,
        ST_DIV,
        ST_ROUND,
        ST_FINISH
    } tbt_state_t;

    // Pass codes: the determinant first, then one pass per output component
    typedef logic [2:0] tbt_pass_t;
    localparam tbt_pass_t PASS_DET = 3'd0;
    localparam tbt_pass_t PASS_TX  = 3'd1;
    localparam tbt_pass_t PASS_TY  = 3'd2;
    localparam tbt_pass_t PASS_TZ  = 3'd3;
    localparam tbt_pass_t PASS_BX  = 3'd4;
    localparam tbt_pass_t PASS_BY  = 3'd5;
    localparam tbt_pass_t PASS_BZ  = 3'd6;

    // Vertex position within a triangle
    typedef logic [1:0] tbt_phase_t;
    localparam tbt_phase_t PHASE_FIRST  = 2'd0;
    localparam tbt_phase_t PHASE_SECOND = 2'd1;
    localparam tbt_phase_t PHASE_THIRD  = 2'd2;

    // Signed fixed-point value as carried on the buses
    typedef logic signed [31:0] fix_t;

endpackage

/* design/triangle_tangent_bitangent_top.sv */
// Per-triangle tangent and bitangent unit, top level.
// One 32x32 multiplier and one restoring divider shared under a sequencer.
// Depends on tbt_pkg.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  --------+-----+-------------------------------------------------+-----------
//  s_      | in  | pos_x, pos_y, pos_z, tex_u, tex_v (160 bits)     | -
//  m_      | out | tangent_x/y/z, bitangent_x/y/z (192 bits)        | degenerate
//
// The first two vertices of a triangle are taken one per cycle. The third vertex
// starts the sequencer: ST_MUL0, ST_MUL1, ST_SUB and ST_NORM for the determinant,
// then per output component the same multiply/normalize states, 63+FRAC_BITS
// divider steps and a rounding state. A zero determinant skips the component
// passes and goes from ST_NORM to ST_FINISH with zero vectors flagged degenerate.
// Reset (synchronous, aresetn low) clears the vertex phase, sequencer and
// output valid. A stalled output register does not block vertex intake; only a
// finished triangle waits for the output register to free up.
module triangle_tangent_bitangent_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // vertex stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
    // triangle result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // tangent_x/y/z, bitangent_x/y/z
    output logic [0:0]   m_tuser    // degenerate
);
    import tbt_pkg::*;

    localparam int DIV_STEPS = 63 + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    localparam logic signed [32:0] SAT_HI = 33'sd2147483647;
    localparam logic signed [32:0] SAT_LO = -33'sd2147483647;

    // Difference saturated to the symmetric 32-bit range
    function automatic fix_t sat_delta(input fix_t a, input fix_t b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d > SAT_HI) begin
            d = SAT_HI;
        end else if (d < SAT_LO) begin
            d = SAT_LO;
        end
        return d[31:0];
    endfunction

    // Input unpack
    fix_t in_pos [3];
    fix_t in_u, in_v;
    assign in_pos[0] = s_tdata[31:0];
    assign in_pos[1] = s_tdata[63:32];
    assign in_pos[2] = s_tdata[95:64];
    assign in_u      = s_tdata[127:96];
    assign in_v      = s_tdata[159:128];

    // Control registers
    tbt_state_t       state_reg, state_next;
    tbt_phase_t       phase_reg, phase_next;
    tbt_pass_t        pass_reg, pass_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    // Held vertices and deltas
    fix_t held_pos_reg [6];
    fix_t held_pos_next [6];
    fix_t held_tex_reg [4];
    fix_t held_tex_next [4];
    fix_t dp1_reg [3];
    fix_t dp1_next [3];
    fix_t dp2_reg [3];
    fix_t dp2_next [3];
    fix_t du1_reg, du1_next, dv1_reg, dv1_next;
    fix_t du2_reg, du2_next, dv2_reg, dv2_next;

    // Arithmetic datapath
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [62:0]        d_reg, d_next;
    logic               det_neg_reg, det_neg_next;
    logic [62:0]        n_reg, n_next;
    logic [62:0]        rem_reg, rem_next;
    logic [31:0]        q_reg, q_next;
    logic               sat_reg, sat_next;
    logic               neg_reg, neg_next;

    // Result working set and output register
    fix_t         res_reg [6];
    fix_t         res_next [6];
    logic         degen_reg, degen_next;
    logic [191:0] out_data_reg, out_data_next;
    logic         out_degen_reg, out_degen_next;

    // Multiplier operand select
    fix_t       mul_a, mul_b;
    logic       term_sel;
    logic [2:0] lane_full;
    logic [1:0] lane;

    assign term_sel = (state_reg == ST_MUL1);

    always_comb begin
        lane_full = 3'd0;
        mul_a     = du1_reg;
        mul_b     = dv2_reg;
        case (pass_reg)
            PASS_DET: begin
                mul_a = term_sel ? du2_reg : du1_reg;
                mul_b = term_sel ? dv1_reg : dv2_reg;
            end
            PASS_TX, PASS_TY, PASS_TZ: begin
                lane_full = pass_reg - PASS_TX;
            end
            PASS_BX, PASS_BY, PASS_BZ: begin
                lane_full = pass_reg - PASS_BX;
            end
            default: begin
                lane_full = 3'd0;
            end
        endcase
        lane = lane_full[1:0];
        case (pass_reg)
            PASS_TX, PASS_TY, PASS_TZ: begin
                // T = dP1*dv2 - dP2*dv1
                mul_a = term_sel ? dp2_reg[lane] : dp1_reg[lane];
                mul_b = term_sel ? dv1_reg : dv2_reg;
            end
            PASS_BX, PASS_BY, PASS_BZ: begin
                // B = dP2*du1 - dP1*du2
                mul_a = term_sel ? dp1_reg[lane] : dp2_reg[lane];
                mul_b = term_sel ? du2_reg : du1_reg;
            end
            default: begin
            end
        endcase
    end

    // Shared multiplier, registered
    assign prod_next = 64'(mul_a) * 64'(mul_b);

    // Divider step and rounding helpers
    logic [63:0] acc_abs;
    logic [63:0] rem_sh;
    logic [63:0] rem_diff;
    logic        step_ge;
    logic        rnd_up;
    logic [32:0] q_rnd;
    logic [32:0] q_neg;
    fix_t        quot;
    logic [2:0]  res_idx;

    assign acc_abs  = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign rem_sh   = {rem_reg, n_reg[62]};
    assign rem_diff = rem_sh - {1'b0, d_reg};
    assign step_ge  = (rem_sh >= {1'b0, d_reg});
    assign rnd_up   = ({rem_reg, 1'b0} >= {1'b0, d_reg});
    assign q_rnd    = {1'b0, q_reg} + 33'(rnd_up);
    assign q_neg    = -q_rnd;
    assign res_idx  = pass_reg - PASS_TX;

    // Rounded, saturated quotient
    always_comb begin
        if (neg_reg) begin
            if (sat_reg || q_rnd > 33'h0_8000_0000) begin
                quot = 32'sh8000_0000;
            end else begin
                quot = q_neg[31:0];
            end
        end else begin
            if (sat_reg || q_rnd > 33'h0_7FFF_FFFF) begin
                quot = 32'sh7FFF_FFFF;
            end else begin
                quot = q_rnd[31:0];
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        held_pos_next  = held_pos_reg;
        held_tex_next  = held_tex_reg;
        dp1_next       = dp1_reg;
        dp2_next       = dp2_reg;
        du1_next       = du1_reg;
        dv1_next       = dv1_reg;
        du2_next       = du2_reg;
        dv2_next       = dv2_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        det_neg_next   = det_neg_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        degen_next     = degen_reg;
        out_data_next  = out_data_reg;
        out_degen_next = out_degen_reg;

        // output slot frees on a completed transfer
        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (phase_reg)
                        PHASE_FIRST: begin
                            for (int k = 0; k < 3; k++) begin
                                held_pos_next[k] = in_pos[k];
                            end
                            held_tex_next[0] = in_u;
                            held_tex_next[1] = in_v;
                            phase_next       = PHASE_SECOND;
                        end
                        PHASE_SECOND: begin
                            for (int k = 0; k < 3; k++) begin
                                held_pos_next[3 + k] = in_pos[k];
                            end
                            held_tex_next[2] = in_u;
                            held_tex_next[3] = in_v;
                            phase_next       = PHASE_THIRD;
                        end
                        default: begin
                            // third vertex: form deltas and start the sequencer
                            for (int k = 0; k < 3; k++) begin
                                dp1_next[k] = sat_delta(held_pos_reg[3 + k], held_pos_reg[k]);
                                dp2_next[k] = sat_delta(in_pos[k], held_pos_reg[k]);
                            end
                            du1_next   = sat_delta(held_tex_reg[2], held_tex_reg[0]);
                            dv1_next   = sat_delta(held_tex_reg[3], held_tex_reg[1]);
                            du2_next   = sat_delta(in_u, held_tex_reg[0]);
                            dv2_next   = sat_delta(in_v, held_tex_reg[1]);
                            phase_next = PHASE_FIRST;
                            pass_next  = PASS_DET;
                            state_next = ST_MUL0;
                        end
                    endcase
                end
            end
            ST_MUL0: begin
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                acc_next   = prod_reg;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                acc_next   = acc_reg - prod_reg;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (pass_reg == PASS_DET) begin
                    if (acc_reg == 64'sd0) begin
                        for (int k = 0; k < 6; k++) begin
                            res_next[k] = '0;
                        end
                        degen_next = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        d_next       = acc_abs[62:0];
                        det_neg_next = acc_reg[63];
                        degen_next   = 1'b0;
                        pass_next    = PASS_TX;
                        state_next   = ST_MUL0;
                    end
                end else begin
                    n_next     = acc_abs[62:0];
                    neg_next   = acc_reg[63] ^ det_neg_reg;
                    rem_next   = '0;
                    q_next     = '0;
                    sat_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle; overflow past 32 bits is sticky
                rem_next = step_ge ? rem_diff[62:0] : rem_sh[62:0];
                q_next   = {q_reg[30:0], step_ge};
                sat_next = sat_reg | q_reg[31];
                n_next   = {n_reg[61:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                res_next[res_idx] = quot;
                if (pass_reg == PASS_BZ) begin
                    state_next = ST_FINISH;
                end else begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_MUL0;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    out_data_next  = {res_reg[5], res_reg[4], res_reg[3],
                                      res_reg[2], res_reg[1], res_reg[0]};
                    out_degen_next = degen_reg;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PHASE_FIRST;
            pass_reg    <= PASS_DET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pass_reg    <= pass_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        held_pos_reg  <= held_pos_next;
        held_tex_reg  <= held_tex_next;
        dp1_reg       <= dp1_next;
        dp2_reg       <= dp2_next;
        du1_reg       <= du1_next;
        dv1_reg       <= dv1_next;
        du2_reg       <= du2_next;
        dv2_reg       <= dv2_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        d_reg         <= d_next;
        det_neg_reg   <= det_neg_next;
        n_reg         <= n_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        sat_reg       <= sat_next;
        neg_reg       <= neg_next;
        res_reg       <= res_next;
        degen_reg     <= degen_next;
        out_data_reg  <= out_data_next;
        out_degen_reg <= out_degen_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

    // Checks
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && state_next != ST_DIV) |-> (cnt_reg == DIV_LAST))
        else $error("divider left before its last step");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("degenerate result carries nonzero vectors");

    a_no_early_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && phase_reg != PHASE_THIRD) |=> (state_reg == ST_IDLE))
        else $error("sequencer started before the third vertex");

    a_div_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (pass_reg != PASS_DET && pass_reg <= PASS_BZ))
        else $error("divider running on a bad pass");

endmodule
